// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They sample on clk and are disabled
// while rst is high; both names must exist in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence holds at the same edge.
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// When the trigger holds, the consequence holds at the next edge.
`define ASSERT_IMPLIES_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Types, constants and the LFSR step for the I2C sensor packet target.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  localparam logic CFG_SLOT_NUMBER = 1'b0;
  localparam logic CFG_LFSR_SEED   = 1'b1;

  localparam logic [2:0] PKT_LEN       = 3'd6;
  localparam logic [7:0] PKT_MAGIC     = 8'hA5;
  localparam logic [7:0] PKT_STATUS    = 8'h01;
  localparam logic [7:0] CMD_GET_DATA  = 8'h01;
  localparam logic [7:0] LFSR_ZERO_SUB = 8'hA7;
  localparam logic [7:0] PAST_END_BYTE = 8'hFF;

  localparam logic [7:0] SLOT_RESET = 8'd1;
  localparam logic [7:0] SEED_RESET = 8'd49;
  localparam logic [7:0] SEQ_RESET  = 8'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic       read_flag;
    logic [7:0] write_data;
  } isp_req_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] read_data;
  } isp_rsp_t;

  typedef struct packed {
    logic       write;
    logic       index;
    logic [7:0] data;
  } isp_cfg_t;

  function automatic logic [7:0] lfsr_advance(input logic [7:0] v);
    logic       fb;
    logic [7:0] n;
    fb = v[7] ^ v[5] ^ v[4] ^ v[3];
    n = {v[6:0], fb};
    return (n == 8'd0) ? LFSR_ZERO_SUB : n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/i2c_sensor_packet_target.sv
// A transfer accepted on req is held in the input register; its result is then
// registered on rsp. Throughput: one event per cycle while rsp is not stalled;
// the input and result registers let a new event be taken while a result waits.
// Reset: rst is synchronous and active high; it empties both registers and
// restores slot 1, seed 49, sequence 1 and an all-zero packet.
// ----------------------------------------------------------------------------
// i2c_sensor_packet_target
// Byte-level I2C target answering the get-data command with a six-byte packet.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_sensor_packet_target (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  isp_pkg::isp_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output isp_pkg::isp_rsp_t rsp,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);
  import isp_pkg::*;
  `include "assert_macros.svh"

  logic     in_valid;
  isp_req_t in_req;
  logic     advance;
  isp_rsp_t result;
  isp_cfg_t cfg;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign advance   = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_req <= req;
    end
  end

  isp_event u_event (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .ev     (in_req),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  `ASSERT_IMPLIES(a_read_ack, rsp_valid && rsp.read_data != 8'd0, rsp.ack,
    "read byte returned without ack")
  `ASSERT_IMPLIES_NEXT(a_hold_input, in_valid && !advance, in_valid,
    "pending event dropped")
  `ASSERT_IMPLIES_NEXT(a_hold_result, rsp_valid && rsp_stall,
    rsp_valid && rsp == $past(rsp),
    "stalled result changed")

endmodule

`default_nettype wire

// File: hw/rtl/isp_event.sv
// ----------------------------------------------------------------------------
// isp_event
// Transaction state, packet store and configuration registers. Handles one
// bus event per cycle while fire is high; the result is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_event (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  isp_pkg::isp_req_t ev,
  input  isp_pkg::isp_cfg_t cfg,
  output isp_pkg::isp_rsp_t result
);
  import isp_pkg::*;
  `include "assert_macros.svh"

  logic [7:0] slot_number;
  logic [7:0] sequence_count;
  logic [7:0] lfsr_value;
  logic [7:0] command_byte;
  logic [2:0] byte_position;
  logic       command_ok;
  logic       reading;
  logic [7:0] packet_store [PKT_LEN];

  logic [7:0] command_byte_next;
  logic [2:0] byte_position_next;
  logic       command_ok_next;
  logic       reading_next;
  logic       capture;
  logic       advance_seq;
  logic       stop_ok;
  logic [7:0] stored_byte;
  logic [7:0] checksum;

  assign stop_ok  = reading && command_ok && (byte_position >= PKT_LEN);
  assign checksum = PKT_MAGIC ^ slot_number ^ PKT_STATUS ^ sequence_count ^ lfsr_value;

  always_comb begin
    unique case (byte_position)
      3'd0: stored_byte = packet_store[0];
      3'd1: stored_byte = packet_store[1];
      3'd2: stored_byte = packet_store[2];
      3'd3: stored_byte = packet_store[3];
      3'd4: stored_byte = packet_store[4];
      3'd5: stored_byte = packet_store[5];
      default: stored_byte = PAST_END_BYTE;
    endcase
  end

  always_comb begin
    command_byte_next  = command_byte;
    byte_position_next = byte_position;
    command_ok_next    = command_ok;
    reading_next       = reading;
    capture            = 1'b0;
    advance_seq        = 1'b0;
    result.ack         = 1'b1;
    result.read_data   = 8'd0;
    unique case (ev.req_type)
      REQ_START: begin
        reading_next       = ev.read_flag;
        byte_position_next = 3'd0;
        if (ev.read_flag) begin
          if (!command_ok || command_byte != CMD_GET_DATA) begin
            result.ack = 1'b0;
          end else begin
            capture = 1'b1;
          end
        end else begin
          command_byte_next = 8'd0;
          command_ok_next   = 1'b0;
        end
      end
      REQ_WRITE: begin
        if (byte_position != 3'd0) begin
          result.ack = 1'b0;
        end else begin
          byte_position_next = 3'd1;
          command_byte_next  = ev.write_data;
          command_ok_next    = (ev.write_data == CMD_GET_DATA);
          result.ack         = (ev.write_data == CMD_GET_DATA);
        end
      end
      REQ_READ: begin
        result.read_data = stored_byte;
        if (byte_position < PKT_LEN) begin
          byte_position_next = byte_position + 3'd1;
        end
      end
      REQ_STOP: begin
        if (stop_ok) begin
          advance_seq     = 1'b1;
          command_ok_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_number    <= SLOT_RESET;
      sequence_count <= SEQ_RESET;
      lfsr_value     <= SEED_RESET;
      command_byte   <= 8'd0;
      byte_position  <= 3'd0;
      command_ok     <= 1'b0;
      reading        <= 1'b0;
      for (int i = 0; i < PKT_LEN; i++) begin
        packet_store[i] <= 8'd0;
      end
    end else begin
      if (fire) begin
        command_byte  <= command_byte_next;
        byte_position <= byte_position_next;
        command_ok    <= command_ok_next;
        reading       <= reading_next;
        if (capture) begin
          packet_store[0] <= PKT_MAGIC;
          packet_store[1] <= slot_number;
          packet_store[2] <= PKT_STATUS;
          packet_store[3] <= sequence_count;
          packet_store[4] <= lfsr_value;
          packet_store[5] <= checksum;
        end
        if (advance_seq) begin
          sequence_count <= sequence_count + 8'd1;
          lfsr_value     <= lfsr_advance(lfsr_value);
        end
      end
      if (cfg.write) begin
        unique case (cfg.index)
          CFG_SLOT_NUMBER: slot_number <= cfg.data;
          CFG_LFSR_SEED:   lfsr_value  <= cfg.data;
        endcase
      end
    end
  end

  `ASSERT_ALWAYS(a_pos_range, byte_position <= PKT_LEN, "byte position past packet end")
  `ASSERT_ALWAYS(a_checksum,
    packet_store[5] == (packet_store[0] ^ packet_store[1] ^ packet_store[2] ^
                        packet_store[3] ^ packet_store[4]),
    "packet checksum mismatch")
  `ASSERT_IMPLIES_NEXT(a_stop_clears,
    fire && !cfg.write && ev.req_type == REQ_STOP && stop_ok,
    !command_ok && sequence_count == $past(sequence_count) + 8'd1,
    "completed read did not advance sequence")

endmodule

`default_nettype wire

// File: tb/sv/i2c_sensor_packet_target_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_sensor_packet_target_test
// Self-checking test of the I2C sensor packet target. Bus events go in on the
// req channel and a local predictor of the target's command, packet and
// sequence state works out the reply to each one; every reply taken from the
// rsp channel is checked field by field against the oldest predicted reply.
// Directed events cover the packet read, past-end reads and refused starts
// and bytes. Register settings include the extremes and a zero LFSR seed.
// Random traffic is mostly well-formed get-data transactions with random
// content, mixed with broken sequences and noise, under random sender gaps
// and receiver stalls; a back-pressure test adds a long receiver hold-off.
// ----------------------------------------------------------------------------

module i2c_sensor_packet_target_test;
  import isp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_EVENTS = 900;
  localparam int MAX_PRINTED = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  isp_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  isp_rsp_t rsp;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  i2c_sensor_packet_target dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic [7:0] slot_now;
  logic [7:0] seed_now;
  logic [7:0] seq_now;
  logic [7:0] lfsr_now;
  logic [7:0] cmd_now;
  logic [2:0] pos_now;
  logic cmd_ok_now;
  logic reading_now;
  logic [7:0] snap [0:5];

  isp_rsp_t replies_due [$];
  isp_rsp_t want;
  int events_sent = 0;
  int replies_checked = 0;
  int packets_completed = 0;
  int settings_applied = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  bit gaps_on = 1'b1;
  int burst_left = 0;

  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int phase_left = 0;

  function automatic logic [7:0] lfsr_next_value(input logic [7:0] b);
    logic [7:0] n;
    n = {b[6:0], ^(b & 8'hB8)};
    return (n == 8'd0) ? LFSR_ZERO_SUB : n;
  endfunction

  task automatic predictor_reset();
    slot_now = SLOT_RESET;
    seed_now = SEED_RESET;
    seq_now = SEQ_RESET;
    lfsr_now = SEED_RESET;
    cmd_now = 8'd0;
    pos_now = 3'd0;
    cmd_ok_now = 1'b0;
    reading_now = 1'b0;
    for (int i = 0; i < 6; i++) snap[i] = 8'd0;
  endtask

  task automatic apply_register(input logic idx, input logic [7:0] d);
    if (idx == CFG_SLOT_NUMBER) begin
      slot_now = d;
    end else begin
      seed_now = d;
      lfsr_now = d;
    end
    settings_applied++;
  endtask

  function automatic isp_rsp_t bus_event_reply(input isp_req_t ev);
    isp_rsp_t r;
    r.ack = 1'b1;
    r.read_data = 8'd0;
    case (ev.req_type)
      REQ_START: begin
        reading_now = ev.read_flag;
        pos_now = 3'd0;
        if (ev.read_flag) begin
          if (!cmd_ok_now || cmd_now != CMD_GET_DATA) begin
            r.ack = 1'b0;
          end else begin
            snap[0] = PKT_MAGIC;
            snap[1] = slot_now;
            snap[2] = PKT_STATUS;
            snap[3] = seq_now;
            snap[4] = lfsr_now;
            snap[5] = PKT_MAGIC ^ slot_now ^ PKT_STATUS ^ seq_now ^ lfsr_now;
          end
        end else begin
          cmd_now = 8'd0;
          cmd_ok_now = 1'b0;
        end
      end
      REQ_WRITE: begin
        if (pos_now != 3'd0) begin
          r.ack = 1'b0;
        end else begin
          pos_now = 3'd1;
          cmd_now = ev.write_data;
          cmd_ok_now = (ev.write_data == CMD_GET_DATA);
          r.ack = cmd_ok_now;
        end
      end
      REQ_READ: begin
        if (pos_now >= PKT_LEN) begin
          r.read_data = PAST_END_BYTE;
        end else begin
          r.read_data = snap[pos_now];
          pos_now = pos_now + 3'd1;
        end
      end
      default: begin
        if (reading_now && cmd_ok_now && pos_now >= PKT_LEN) begin
          seq_now = seq_now + 8'd1;
          lfsr_now = lfsr_next_value(lfsr_now);
          cmd_ok_now = 1'b0;
          packets_completed++;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] exp_val,
                                 input logic [7:0] got_val);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at reply %0d: %s expected %h got %h",
               replies_checked, what, exp_val, got_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) apply_register(cfg_index, cfg_data);
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply, read_data", 8'd0, rsp.read_data);
        end else begin
          want = replies_due.pop_front();
          if (rsp.ack !== want.ack) report_mismatch("ack", 8'(want.ack), 8'(rsp.ack));
          if (rsp.read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, rsp.read_data);
          replies_checked++;
        end
      end
      if (req_valid && req_stall == 1'b0) replies_due.push_back(bus_event_reply(req));
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        phase_left <= $urandom_range(8, 80);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= ~rsp_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[i2c_sensor_packet_target] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(input isp_req_t ev);
    int gap;
    req <= ev;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    events_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic isp_req_t bus_event(input logic [1:0] kind, input logic rd,
                                         input logic [7:0] wd);
    isp_req_t ev;
    ev.req_type = kind;
    ev.read_flag = rd;
    ev.write_data = wd;
    return ev;
  endfunction

  task automatic bus_start(input logic rd);
    send_item(bus_event(REQ_START, rd, 8'($urandom_range(0, 255))));
  endtask

  task automatic bus_write(input logic [7:0] b);
    send_item(bus_event(REQ_WRITE, 1'($urandom_range(0, 1)), b));
  endtask

  task automatic bus_reads(input int n);
    repeat (n)
      send_item(bus_event(REQ_READ, 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255))));
  endtask

  task automatic bus_stop();
    send_item(bus_event(REQ_STOP, 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255))));
  endtask

  task automatic get_data_packet(input int nreads);
    bus_start(1'b0);
    bus_write(CMD_GET_DATA);
    bus_start(1'b1);
    bus_reads(nreads);
    bus_stop();
  endtask

  task automatic wait_all_replies();
    req_valid <= 1'b0;
    while (replies_checked != events_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_get_data_packet();
    bus_reads(2);
    get_data_packet(7);
    bus_write(8'hFF);
  endtask

  task automatic test_refusals();
    bus_start(1'b1);
    bus_reads(1);
    bus_start(1'b0);
    bus_write(8'h00);
    bus_write(CMD_GET_DATA);
    bus_start(1'b1);
    bus_stop();
    bus_start(1'b0);
    bus_write(CMD_GET_DATA);
    bus_start(1'b1);
    bus_reads(3);
    bus_stop();
  endtask

  task automatic test_register_settings();
    logic [7:0] slots [0:3];
    logic [7:0] seeds [0:3];
    slots = '{8'h00, 8'hFF, 8'h80, 8'h00};
    seeds = '{8'h00, 8'hFF, 8'h01, 8'h00};
    slots[3] = 8'($urandom_range(0, 255));
    seeds[3] = 8'($urandom_range(1, 255));
    for (int i = 0; i < 4; i++) begin
      wait_all_replies();
      write_reg(CFG_SLOT_NUMBER, slots[i]);
      write_reg(CFG_LFSR_SEED, seeds[i]);
      get_data_packet(6);
      get_data_packet(6);
    end
  endtask

  task automatic test_backpressure();
    wait_all_replies();
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (4) get_data_packet(6);
    gaps_on = 1'b1;
    wait_all_replies();
  endtask

  task automatic random_transaction();
    int kind;
    int nreads;
    kind = $urandom_range(0, 9);
    nreads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 6 + $urandom_range(0, 1);
    if (kind <= 5) begin
      bus_start(1'b0);
      bus_write(CMD_GET_DATA);
      if ($urandom_range(0, 5) == 0) bus_write(8'($urandom_range(0, 255)));
      bus_start(1'b1);
      bus_reads(nreads);
      if ($urandom_range(0, 7) == 0) begin
        bus_start(1'b1);
        bus_reads($urandom_range(1, 7));
      end
      bus_stop();
    end else if (kind == 6) begin
      bus_start(1'b0);
      bus_write(($urandom_range(0, 1) == 0) ? CMD_GET_DATA : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
        bus_start(1'b1);
        bus_reads(nreads);
      end
      bus_stop();
    end else if (kind == 7) begin
      bus_start(1'b1);
      bus_reads($urandom_range(0, 3));
      bus_stop();
    end else begin
      repeat ($urandom_range(1, 4))
        send_item(bus_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255))));
    end
  endtask

  task automatic test_random_traffic();
    int first;
    int last_setting;
    first = events_sent;
    last_setting = events_sent;
    while (events_sent - first < RANDOM_EVENTS) begin
      random_transaction();
      if (events_sent - last_setting >= 250) begin
        wait_all_replies();
        write_reg(CFG_SLOT_NUMBER, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
        write_reg(CFG_LFSR_SEED, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        last_setting = events_sent;
      end
    end
  endtask

  initial begin
    predictor_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_get_data_packet();
    test_refusals();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    wait_all_replies();
    repeat (8) @(posedge clk);
    $display("Run covered %0d bus events and %0d checked replies, including %0d",
             events_sent, replies_checked, packets_completed);
    $display("completed packet reads, under %0d register writes and a receiver hold-off.",
             settings_applied);
    if (mismatches == 0) begin
      $display("[i2c_sensor_packet_target] OK");
    end else begin
      $display("[i2c_sensor_packet_target] ERROR");
    end
    $finish;
  end

endmodule
